>>> rtl/core/x64uw_pkg.sv
`default_nettype none
package x64uw_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 8;
	localparam int unsigned S_TDATA_W = 16;
	localparam int unsigned M_TDATA_W = 56;
	localparam int unsigned M_TUSER_W = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_UNWIND_VERSION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROLOGUE_SIZE  = 2'd1;

	localparam logic [1:0] VER_1 = 2'd1;
	localparam logic [1:0] VER_2 = 2'd2;
	localparam logic [1:0] VERSION_RESET = VER_1;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_WARN      = 3'd1;
	localparam logic [2:0] ST_BAD_ORDER = 3'd2;
	localparam logic [2:0] ST_TRUNC     = 3'd3;
	localparam logic [2:0] ST_BAD_ALLOC = 3'd4;
	localparam logic [2:0] ST_BAD_MACH  = 3'd5;

	localparam logic [3:0] OPC_PUSH        = 4'd0;
	localparam logic [3:0] OPC_ALLOC_LARGE = 4'd1;
	localparam logic [3:0] OPC_ALLOC_SMALL = 4'd2;
	localparam logic [3:0] OPC_SET_FP      = 4'd3;
	localparam logic [3:0] OPC_SAVE        = 4'd4;
	localparam logic [3:0] OPC_SAVE_FAR    = 4'd5;
	localparam logic [3:0] OPC_EPILOG      = 4'd6;
	localparam logic [3:0] OPC_SPARE       = 4'd7;
	localparam logic [3:0] OPC_XMM         = 4'd8;
	localparam logic [3:0] OPC_XMM_FAR     = 4'd9;
	localparam logic [3:0] OPC_MACHFRAME   = 4'd10;

	localparam logic [3:0] KIND_OPAQUE = 4'd11;

	localparam logic [1:0] SLOTS_ONE   = 2'd1;
	localparam logic [1:0] SLOTS_TWO   = 2'd2;
	localparam logic [1:0] SLOTS_THREE = 2'd3;

	typedef struct packed {
		logic        halted;
		logic [1:0]  pending;
		logic [7:0]  held_off;
		logic [3:0]  held_opc;
		logic [3:0]  held_info;
		logic [1:0]  held_total;
		logic [31:0] acc;
		logic [7:0]  prev_off;
		logic        prev_valid;
	} uw_state_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  op_kind;
		logic [7:0]  code_offset;
		logic [3:0]  op_info;
		logic [3:0]  reg_number;
		logic [31:0] stack_offset;
		logic [1:0]  slot_count;
		logic        record_end;
	} uw_result_t;

	function automatic logic [3:0] kind_of(input logic [3:0] opc, input logic [1:0] ver);
		logic [3:0] k;
		begin
			if (opc > OPC_MACHFRAME)
				k = KIND_OPAQUE;
			else if ((opc == OPC_EPILOG || opc == OPC_SPARE) && ver != VER_2)
				k = KIND_OPAQUE;
			else
				k = opc;
			return k;
		end
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/x64uw_decode.sv
`default_nettype none
module x64uw_decode (
	input  wire x64uw_pkg::uw_state_t  cur,
	input  wire logic [7:0]            lo,
	input  wire logic [7:0]            hi,
	input  wire logic                  last,
	input  wire logic [1:0]            version,
	input  wire logic [7:0]            prologue,
	output x64uw_pkg::uw_state_t       nxt,
	output x64uw_pkg::uw_result_t      res,
	output logic                       emit
);
	import x64uw_pkg::*;

	logic        fatal;
	logic [2:0]  fstat;
	logic [1:0]  fslots;
	logic [3:0]  fopc;
	logic [3:0]  finfo;
	logic [7:0]  foff;
	logic [15:0] word;
	logic [1:0]  received;
	logic [1:0]  pend_n;
	logic [31:0] acc_n;
	logic [3:0]  opc;
	logic [3:0]  info;
	logic        v2ep;
	logic        bad_off;
	logic [1:0]  need;
	logic [2:0]  stat;
	logic [3:0]  rnum;
	logic [31:0] stack;

	always_comb begin
		nxt      = cur;
		res      = '0;
		emit     = 1'b0;
		fatal    = 1'b0;
		fstat    = ST_OK;
		fslots   = SLOTS_ONE;
		fopc     = '0;
		finfo    = '0;
		foff     = '0;
		word     = {hi, lo};
		received = cur.held_total - cur.pending + 2'd1;
		pend_n   = cur.pending - 2'd1;
		acc_n    = '0;
		opc      = hi[3:0];
		info     = hi[7:4];
		v2ep     = (version == VER_2) && (opc == OPC_EPILOG);
		bad_off  = (!v2ep && (lo > prologue)) ||
			((version == VER_1) && cur.prev_valid && (lo > cur.prev_off));
		need     = SLOTS_ONE;
		stat     = ST_OK;
		rnum     = '0;
		stack    = '0;

		if (cur.halted) begin
			if (last) begin
				nxt.halted     = 1'b0;
				nxt.prev_off   = '0;
				nxt.prev_valid = 1'b0;
			end
		end else if (cur.pending != 2'd0) begin
			acc_n       = (received == SLOTS_TWO) ? {16'd0, word} : {word, cur.acc[15:0]};
			nxt.acc     = acc_n;
			nxt.pending = pend_n;
			if (pend_n != 2'd0) begin
				if (last) begin
					fatal  = 1'b1;
					fstat  = ST_TRUNC;
					fslots = received;
					fopc   = cur.held_opc;
					finfo  = cur.held_info;
					foff   = cur.held_off;
				end
			end else begin
				if (cur.held_total == SLOTS_THREE)
					stack = acc_n;
				else if (cur.held_opc == OPC_XMM)
					stack = {12'd0, acc_n[15:0], 4'd0};
				else
					stack = {13'd0, acc_n[15:0], 3'd0};
				emit             = 1'b1;
				res.status       = ST_OK;
				res.op_kind      = kind_of(cur.held_opc, version);
				res.code_offset  = cur.held_off;
				res.op_info      = cur.held_info;
				res.reg_number   = (cur.held_opc == OPC_ALLOC_LARGE) ? 4'd0 : cur.held_info;
				res.stack_offset = stack;
				res.slot_count   = cur.held_total;
				res.record_end   = last;
				nxt.held_off     = '0;
				nxt.held_opc     = '0;
				nxt.held_info    = '0;
				nxt.held_total   = '0;
				nxt.acc          = '0;
				if (last) begin
					nxt.prev_off   = '0;
					nxt.prev_valid = 1'b0;
				end
			end
		end else begin
			fopc  = opc;
			finfo = info;
			foff  = lo;
			if (bad_off) begin
				fatal = 1'b1;
				fstat = ST_BAD_ORDER;
			end else begin
				nxt.prev_off   = lo;
				nxt.prev_valid = 1'b1;
				case (opc)
					OPC_PUSH: rnum = info;
					OPC_ALLOC_LARGE: begin
						if (info == 4'd0)
							need = SLOTS_TWO;
						else if (info == 4'd1)
							need = SLOTS_THREE;
						else begin
							fatal = 1'b1;
							fstat = ST_BAD_ALLOC;
						end
					end
					OPC_ALLOC_SMALL: stack = {25'd0, ({1'b0, info} + 5'd1), 2'd0} << 1;
					OPC_SET_FP: if (info != 4'd0) stat = ST_WARN;
					OPC_SAVE, OPC_XMM: need = SLOTS_TWO;
					OPC_SAVE_FAR, OPC_XMM_FAR: need = SLOTS_THREE;
					OPC_EPILOG: begin
						if (version == VER_2)
							stack = {20'd0, info, lo};
						else
							stat = ST_WARN;
					end
					OPC_SPARE: if (version != VER_2) stat = ST_WARN;
					OPC_MACHFRAME: begin
						if (info > 4'd1) begin
							fatal = 1'b1;
							fstat = ST_BAD_MACH;
						end
					end
					default: stat = ST_WARN;
				endcase
				if (!fatal) begin
					if (need != SLOTS_ONE) begin
						if (last) begin
							fatal = 1'b1;
							fstat = ST_TRUNC;
						end else begin
							nxt.held_off   = lo;
							nxt.held_opc   = opc;
							nxt.held_info  = info;
							nxt.held_total = need;
							nxt.pending    = need - 2'd1;
							nxt.acc        = '0;
						end
					end else begin
						emit             = 1'b1;
						res.status       = stat;
						res.op_kind      = kind_of(opc, version);
						res.code_offset  = lo;
						res.op_info      = info;
						res.reg_number   = rnum;
						res.stack_offset = stack;
						res.slot_count   = SLOTS_ONE;
						res.record_end   = last;
						if (last) begin
							nxt.prev_off   = '0;
							nxt.prev_valid = 1'b0;
						end
					end
				end
			end
		end

		if (fatal) begin
			emit             = 1'b1;
			res.status       = fstat;
			res.op_kind      = kind_of(fopc, version);
			res.code_offset  = foff;
			res.op_info      = finfo;
			res.reg_number   = '0;
			res.stack_offset = '0;
			res.slot_count   = fslots;
			res.record_end   = 1'b1;
			nxt              = '0;
			nxt.halted       = !last;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/x64_unwind_code_slot_decoder_core.sv
`default_nettype none
// Decodes a Windows x64 unwind-code array one 16-bit slot per beat, taking a new slot every
// clock cycle unless m_axis_tready stalls the output. A slot passes an input register, is
// decoded combinationally against the running record state and lands in the result
// register; operations with operand slots give their single result on their last slot. Fatal
// errors end the record and the remaining slots up to tlast are dropped. Status and kind
// ride on tuser, record end on tlast. Write unwind_version and prologue_size only while the
// block is idle; both reset to 1 and 0.
module x64_unwind_code_slot_decoder_core (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [x64uw_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [x64uw_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	// offset_byte, info_byte
	input  wire logic [x64uw_pkg::S_TDATA_W-1:0]       s_axis_tdata,
	input  wire logic                                  s_axis_tlast,
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// code_offset, op_info, reg_number, stack_offset, slot_count, zero pad
	output logic [x64uw_pkg::M_TDATA_W-1:0]            m_axis_tdata,
	// status, op_kind
	output logic [x64uw_pkg::M_TUSER_W-1:0]            m_axis_tuser,
	output logic                                       m_axis_tlast
);
	import x64uw_pkg::*;

	logic        valid_s1;
	logic [7:0]  lo_s1;
	logic [7:0]  hi_s1;
	logic        last_s1;
	logic [1:0]  version_q;
	logic [7:0]  prologue_q;
	uw_state_t   state_q;
	uw_state_t   state_nxt;
	uw_result_t  res_nxt;
	uw_result_t  res_q;
	logic        emit;
	logic        out_valid_q;
	logic        out_free;
	logic        fire;

	assign cfg_ready     = 1'b1;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q  <= VERSION_RESET;
			prologue_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_UNWIND_VERSION: version_q <= cfg_data[1:0];
				CFG_PROLOGUE_SIZE:  prologue_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			lo_s1   <= s_axis_tdata[7:0];
			hi_s1   <= s_axis_tdata[15:8];
			last_s1 <= s_axis_tlast;
		end
	end

	x64uw_decode u_decode (
		.cur      (state_q),
		.lo       (lo_s1),
		.hi       (hi_s1),
		.last     (last_s1),
		.version  (version_q),
		.prologue (prologue_q),
		.nxt      (state_nxt),
		.res      (res_nxt),
		.emit     (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= '0;
		else if (fire)
			state_q <= state_nxt;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= fire && emit;
	end

	always_ff @(posedge clk) begin
		if (fire && emit)
			res_q <= res_nxt;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, res_q.slot_count, res_q.stack_offset, res_q.reg_number,
		res_q.op_info, res_q.code_offset};
	assign m_axis_tuser  = {res_q.op_kind, res_q.status};
	assign m_axis_tlast  = res_q.record_end;

	a_halt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.halted |-> (state_q.pending == 2'd0))
		else $error("halted with operand slots pending");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.pending != 2'd0) |-> (state_q.pending < state_q.held_total))
		else $error("pending slot count exceeds operation size");

	a_fatal_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && emit && res_nxt.status > ST_WARN) |-> res_nxt.record_end)
		else $error("fatal result does not end record");

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && state_q.halted) |-> !emit)
		else $error("result emitted while discarding");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && emit) |=> m_axis_tvalid)
		else $error("decoded result not presented");

endmodule
`default_nettype wire
